// File: src/number_to_segment_patterns_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef NUMBER_TO_SEGMENT_PATTERNS_ASSERT_SVH
`define NUMBER_TO_SEGMENT_PATTERNS_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define NTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define NTS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/nts_pkg.sv
package nts_pkg;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned MagW      = 14;
  localparam int unsigned ProdW     = 30;

  localparam logic [7:0] SegDash  = 8'h40;
  localparam logic [7:0] SegPoint = 8'h80;
  localparam logic [7:0] SegBlank = 8'h00;

  localparam logic signed [31:0] DecPosMax = 32'sd9999;
  localparam logic signed [31:0] DecNegMin = -32'sd999;

  // Reciprocal constants for division of a magnitude below 10000.
  localparam logic [15:0]  Recip1000 = 16'd8389;
  localparam int unsigned  Shift1000 = 23;
  localparam logic [15:0]  Recip100  = 16'd5243;
  localparam int unsigned  Shift100  = 19;
  localparam logic [15:0]  Recip10   = 16'd52429;
  localparam int unsigned  Shift10   = 19;

  localparam logic [15:0] HexMask = 16'hFFFF;

  typedef logic [7:0] pattern_t;

  // Standard gfedcba font, dot segment off.
  function automatic pattern_t seg_font(input logic [3:0] nib);
    pattern_t pat;
    case (nib)
      4'h0:    pat = 8'h3F;
      4'h1:    pat = 8'h06;
      4'h2:    pat = 8'h5B;
      4'h3:    pat = 8'h4F;
      4'h4:    pat = 8'h66;
      4'h5:    pat = 8'h6D;
      4'h6:    pat = 8'h7D;
      4'h7:    pat = 8'h07;
      4'h8:    pat = 8'h7F;
      4'h9:    pat = 8'h6F;
      4'hA:    pat = 8'h77;
      4'hB:    pat = 8'h7C;
      4'hC:    pat = 8'h39;
      4'hD:    pat = 8'h5E;
      4'hE:    pat = 8'h79;
      4'hF:    pat = 8'h71;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// File: src/number_to_segment_patterns.sv
// Path: an input transfer fills the input register; the result register takes the item
// when it is empty or its item leaves, so a stalled result holds the item back.
// Throughput: one item per cycle unless the result stalls; the single combinational pass
// (three constant reciprocal multiplies, three digit subtracts) lies between the registers.
// Reset: rst_ni clears both valid flags asynchronously; payload registers keep their data.
module number_to_segment_patterns (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         dots_mask_i,
  input  logic               leading_zeros_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         digit0_pattern_o,
  output logic [7:0]         digit1_pattern_o,
  output logic [7:0]         digit2_pattern_o,
  output logic [7:0]         digit3_pattern_o
);

  // Input register stage.
  logic               s1_valid_q;
  logic               action_q;
  logic signed [31:0] value_q;
  logic [3:0]         dots_q;
  logic               lz_q;

  // Result register stage.
  logic                 out_valid_q;
  nts_pkg::pattern_t    digit_q [nts_pkg::NumDigits];
  nts_pkg::pattern_t    digit_d [nts_pkg::NumDigits];

  logic in_xfer;
  logic s1_advance;

  // The result register takes a new item whenever it is empty or its item leaves this
  // cycle, and the input register refills as soon as its item moves on. So a waiting
  // result never blocks the next input transfer by more than one register.
  assign s1_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q <= action_i;
      value_q  <= value_i;
      dots_q   <= dots_mask_i;
      lz_q     <= leading_zeros_i;
    end
  end

  // Formatting logic between the two registers.
  always_comb begin
    logic                          neg;
    logic                          dec_ok;
    logic [31:0]                   mag_full;
    logic [nts_pkg::MagW-1:0]      mag;
    logic [nts_pkg::ProdW-1:0]     prod1000;
    logic [nts_pkg::ProdW-1:0]     prod100;
    logic [nts_pkg::ProdW-1:0]     prod10;
    logic [3:0]                    q1000;
    logic [6:0]                    q100;
    logic [9:0]                    q10;
    logic [3:0]                    dec_dig [nts_pkg::NumDigits];
    logic [1:0]                    first;
    logic                          found;
    nts_pkg::pattern_t             pat [nts_pkg::NumDigits];
    logic [15:0]                   hex_val;
    logic                          blanking;

    neg      = value_q[31];
    dec_ok   = neg ? (value_q >= nts_pkg::DecNegMin) : (value_q <= nts_pkg::DecPosMax);
    mag_full = neg ? (32'd0 - 32'(value_q)) : 32'(value_q);
    mag      = mag_full[nts_pkg::MagW-1:0];

    // Quotients by 1000, 100 and 10 through reciprocal multiplication; exact for every
    // magnitude that passes the range check.
    prod1000 = nts_pkg::ProdW'(mag) * nts_pkg::ProdW'(nts_pkg::Recip1000);
    prod100  = nts_pkg::ProdW'(mag) * nts_pkg::ProdW'(nts_pkg::Recip100);
    prod10   = nts_pkg::ProdW'(mag) * nts_pkg::ProdW'(nts_pkg::Recip10);
    q1000    = 4'(prod1000 >> nts_pkg::Shift1000);
    q100     = 7'(prod100 >> nts_pkg::Shift100);
    q10      = 10'(prod10 >> nts_pkg::Shift10);

    dec_dig[0] = q1000;
    dec_dig[1] = 4'(q100 - 7'(q1000) * 7'd10);
    dec_dig[2] = 4'(q10 - 10'(q100) * 10'd10);
    dec_dig[3] = 4'(mag - nts_pkg::MagW'(q10) * nts_pkg::MagW'(10));

    // Leftmost nonzero decimal digit; zero itself keeps the rightmost digit.
    first = 2'd3;
    found = 1'b0;
    for (int i = 0; i < nts_pkg::NumDigits; i++) begin
      if (!found && (dec_dig[i] != 4'd0)) begin
        found = 1'b1;
        first = 2'(i);
      end
    end

    hex_val  = value_q[15:0] & nts_pkg::HexMask;
    blanking = 1'b0;

    if (!action_q) begin
      for (int i = 0; i < nts_pkg::NumDigits; i++) begin
        pat[i] = nts_pkg::seg_font(dec_dig[i]);
        if (!lz_q && (2'(i) < first)) begin
          pat[i] = nts_pkg::SegBlank;
        end
      end
      if (neg) begin
        if (lz_q || (first == 2'd0)) begin
          for (int i = 0; i < nts_pkg::NumDigits; i++) begin
            pat[i] = nts_pkg::SegDash;
          end
        end else begin
          pat[first - 2'd1] = nts_pkg::SegDash;
        end
      end
      if (!dec_ok) begin
        for (int i = 0; i < nts_pkg::NumDigits; i++) begin
          pat[i] = nts_pkg::SegDash;
        end
      end
    end else begin
      // Leading zero nibbles are blanked only when some nibble is nonzero.
      blanking = !lz_q && (hex_val != 16'd0);
      for (int i = 0; i < nts_pkg::NumDigits; i++) begin
        pat[i] = nts_pkg::seg_font(hex_val[15 - 4*i -: 4]);
        if (blanking && (hex_val[15 - 4*i -: 4] == 4'd0)) begin
          pat[i] = nts_pkg::SegBlank;
        end else begin
          blanking = 1'b0;
        end
        if (neg) begin
          pat[i] = nts_pkg::SegDash;
        end
      end
    end

    // Mask bit i marks the digit counted i places from the right.
    for (int i = 0; i < nts_pkg::NumDigits; i++) begin
      digit_d[i] = pat[i];
      if (dots_q[nts_pkg::NumDigits - 1 - i]) begin
        digit_d[i] = pat[i] | nts_pkg::SegPoint;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      digit_q <= digit_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign digit0_pattern_o = digit_q[0];
  assign digit1_pattern_o = digit_q[1];
  assign digit2_pattern_o = digit_q[2];
  assign digit3_pattern_o = digit_q[3];

endmodule

// File: src/nts_checker.sv
`include "number_to_segment_patterns_assert.svh"

module nts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         digit0_pattern_o,
  input logic [7:0]         digit1_pattern_o,
  input logic [7:0]         digit2_pattern_o,
  input logic [7:0]         digit3_pattern_o
);

  // All four patterns side by side, leftmost digit in the top byte.
  logic [31:0] digits_all;

  assign digits_all = {digit0_pattern_o, digit1_pattern_o, digit2_pattern_o, digit3_pattern_o};

  `NTS_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result offered during reset")

  `NTS_ASSERT(a_result_held, out_valid_o && !out_ready_i |=> out_valid_o && $stable(digits_all), "stalled result changed")

  `NTS_ASSERT(a_result_two_cycles, in_valid_i && in_ready_o |=> ##1 out_valid_o, "no result two cycles after an input transfer")

  `NTS_ASSERT(a_ready_only_blocked_by_stall, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without a stalled result")

endmodule

bind number_to_segment_patterns nts_checker u_nts_checker (.*);
